/* src/mi3x3_pkg.sv */
// Shared constants, tables and types for the 3x3 matrix inverse unit.
package mi3x3_pkg;

  // Default word and fraction sizes of the matrix entries.
  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Singularity threshold register: width and reset value (units of 2^-3F).
  localparam int              THR_W     = 63;
  localparam logic [THR_W-1:0] THR_RESET = 63'd281474977;

  // Number of matrix entries and of divider lanes.
  localparam int NUM_ELEM = 9;

  // Adjugate entry k = m[ADJ_IDX[k][0]] * m[ADJ_IDX[k][1]]
  //                  - m[ADJ_IDX[k][2]] * m[ADJ_IDX[k][3]], entries row by row.
  localparam int ADJ_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

  // Control that travels beside the datapath.
  typedef struct packed {
    logic valid;
    logic singular;
  } mi3x3_ctrl_t;

endpackage

/* src/mi3x3_cofactor.sv */
// Front end: adjugate entries, exact determinant and singularity test.
module mi3x3_cofactor #(
  parameter int W = mi3x3_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [W-1:0]           elem_i [mi3x3_pkg::NUM_ELEM],
  input  logic [mi3x3_pkg::THR_W-1:0]   thr_i,
  output logic [2*W:0]                  adj_mag_o [mi3x3_pkg::NUM_ELEM],
  output logic                          adj_neg_o [mi3x3_pkg::NUM_ELEM],
  output logic [3*W+2:0]                absdet_o,
  output logic                          det_neg_o,
  output mi3x3_pkg::mi3x3_ctrl_t        ctrl_o
);

  localparam int N  = mi3x3_pkg::NUM_ELEM;
  localparam int AW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int TW = (DW > mi3x3_pkg::THR_W) ? DW : mi3x3_pkg::THR_W;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [2*W-1:0] pa_r [N];
  logic signed [2*W-1:0] pb_r [N];
  logic signed [W-1:0]   m1_r [3];
  logic signed [W-1:0]   m2_r [3];
  logic signed [AW-1:0]  adj2_r [N];
  logic signed [AW-1:0]  adj3_r [N];
  logic signed [2*W:0]   pl_r [3];
  logic signed [2*W:0]   ph_r [3];
  logic signed [AW-1:0]  adj4_r [N];
  logic signed [DW-1:0]  det_r;
  logic [AW-1:0]         mag_r [N];
  logic                  neg_r [N];
  logic [DW-1:0]         absdet_r;
  logic                  det_neg_r;
  logic                  sing_r;

  logic signed [DW-1:0]  det_nxt;
  logic [DW-1:0]         absdet_nxt;
  logic [TW-1:0]         absdet_ext;
  logic [TW-1:0]         thr_ext;

  // Valid bits follow the datapath stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 1: the eighteen cofactor products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        pa_r[k] <= elem_i[mi3x3_pkg::ADJ_IDX[k][0]] * elem_i[mi3x3_pkg::ADJ_IDX[k][1]];
        pb_r[k] <= elem_i[mi3x3_pkg::ADJ_IDX[k][2]] * elem_i[mi3x3_pkg::ADJ_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
        m1_r[j] <= elem_i[j];
      end
    end
  end

  // Stage 2: adjugate entries.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        adj2_r[k] <= AW'(pa_r[k]) - AW'(pb_r[k]);
      end
      m2_r <= m1_r;
    end
  end

  // Stage 3: determinant partial products, top row against adjugate column 0.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pl_r[j] <= m2_r[j] * $signed({1'b0, adj2_r[3*j][W-1:0]});
        ph_r[j] <= m2_r[j] * $signed(adj2_r[3*j][AW-1:W]);
      end
      adj3_r <= adj2_r;
    end
  end

  // Stage 4: recombine the partial products into the exact determinant.
  always_comb begin
    det_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      det_nxt = det_nxt + (DW'(ph_r[j]) <<< W) + DW'(pl_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= det_nxt;
      adj4_r <= adj3_r;
    end
  end

  // Stage 5: magnitudes, signs and the singularity decision.
  assign absdet_nxt = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign absdet_ext = TW'(absdet_nxt);
  assign thr_ext    = TW'(thr_i);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        mag_r[k] <= adj4_r[k][AW-1] ? AW'(-adj4_r[k]) : AW'(adj4_r[k]);
        neg_r[k] <= adj4_r[k][AW-1];
      end
      absdet_r  <= absdet_nxt;
      det_neg_r <= det_r[DW-1];
      sing_r    <= (det_r == '0) || (absdet_ext < thr_ext);
    end
  end

  assign adj_mag_o       = mag_r;
  assign adj_neg_o       = neg_r;
  assign absdet_o        = absdet_r;
  assign det_neg_o       = det_neg_r;
  assign ctrl_o.valid    = v5_r;
  assign ctrl_o.singular = sing_r;

endmodule

/* src/mi3x3_div_lane.sv */
// One divider lane: pipelined restoring division of an adjugate entry by the determinant.
module mi3x3_div_lane #(
  parameter int W = mi3x3_pkg::WORD_BITS_DEF,
  parameter int F = mi3x3_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2*W:0]        adj_mag_i,
  input  logic                neg_i,
  input  logic [3*W+2:0]      absdet_i,
  output logic signed [W-1:0] val_o,
  output logic                sat_o
);

  localparam int DW = 3 * W + 3;
  localparam int CW = DW + W + 2 * F;
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] HALF   = {1'b1, {(W-1){1'b0}}};

  logic [CW-1:0] num_w;
  logic [CW-1:0] den_w;

  logic [DW-1:0] r_r   [W+1];
  logic [W-1:0]  q_r   [W+1];
  logic [W-1:0]  nlo_r [W+1];
  logic [DW-1:0] d_r   [W+1];
  logic          neg_r [W+1];
  logic          ovf_r [W+1];

  logic [W-1:0]  q_fin;
  logic [W-1:0]  val_nxt;
  logic          sat_nxt;
  logic [W-1:0]  val_r;
  logic          sat_r;

  // Numerator |adj| * 2^2F; the quotient fits W bits unless num >= den * 2^W.
  assign num_w = CW'(adj_mag_i) << (2 * F);
  assign den_w = CW'(absdet_i) << W;

  // Stage 0: overflow check and the partial remainder above the quotient bits.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= num_w[W +: DW];
      nlo_r[0] <= num_w[W-1:0];
      q_r[0]   <= '0;
      d_r[0]   <= absdet_i;
      neg_r[0] <= neg_i;
      ovf_r[0] <= (num_w >= den_w);
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= W; s++) begin : g_step
    logic [DW:0] rs;
    logic        take;
    assign rs   = {r_r[s-1], nlo_r[s-1][W-s]};
    assign take = (rs >= {1'b0, d_r[s-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s]   <= take ? DW'(rs - {1'b0, d_r[s-1]}) : rs[DW-1:0];
        q_r[s]   <= {q_r[s-1][W-2:0], take};
        nlo_r[s] <= nlo_r[s-1];
        d_r[s]   <= d_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  // Sign and clipping to the signed word range.
  assign q_fin = q_r[W];

  always_comb begin
    if (neg_r[W]) begin
      sat_nxt = ovf_r[W] || (q_fin > HALF);
      val_nxt = sat_nxt ? HALF : W'(-q_fin);
    end else begin
      sat_nxt = ovf_r[W] || q_fin[W-1];
      val_nxt = sat_nxt ? MAXPOS : q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign val_o = $signed(val_r);
  assign sat_o = sat_r;

endmodule

/* src/mi3x3_merge.sv */
// Merge of the lane results, identity substitution and the output skid buffer.
module mi3x3_merge #(
  parameter int W = mi3x3_pkg::WORD_BITS_DEF,
  parameter int F = mi3x3_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mi3x3_pkg::mi3x3_ctrl_t        ctrl_i,
  input  logic signed [W-1:0]           val_i [mi3x3_pkg::NUM_ELEM],
  input  logic                          sat_i [mi3x3_pkg::NUM_ELEM],
  output logic                          en_o,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [((9*W+7)/8)*8-1:0]      out_tdata,
  output logic [1:0]                    out_tuser
);

  localparam int  N      = mi3x3_pkg::NUM_ELEM;
  localparam int  OTW    = ((9 * W + 7) / 8) * 8;
  localparam bit  ID_SAT = (F > W - 2);
  localparam logic [W-1:0] ONE = ID_SAT ? {1'b0, {(W-1){1'b1}}} : (W'(1) << F);

  logic [OTW-1:0] data_w;
  logic [1:0]     user_w;
  logic           emit;
  logic           pop;

  logic           out_valid_r;
  logic [OTW-1:0] out_data_r;
  logic [1:0]     out_user_r;
  logic           skid_valid_r;
  logic [OTW-1:0] skid_data_r;
  logic [1:0]     skid_user_r;

  // Combine lanes: identity on a singular matrix, else the quotients.
  always_comb begin
    logic any_sat;
    data_w  = '0;
    any_sat = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (ctrl_i.singular) begin
        data_w[k*W +: W] = (k == 0 || k == 4 || k == 8) ? ONE : '0;
      end else begin
        data_w[k*W +: W] = val_i[k];
      end
      any_sat = any_sat | sat_i[k];
    end
    user_w[0] = ctrl_i.singular;
    user_w[1] = ctrl_i.singular ? ID_SAT : any_sat;
  end

  // The pipeline moves whenever the skid stage is empty.
  assign en_o = !skid_valid_r;
  assign emit = ctrl_i.valid && en_o;
  assign pop  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop || !out_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (emit) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the output and skid stages.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop || !out_valid_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (emit) begin
      if (!out_valid_r || pop) begin
        out_data_r <= data_w;
        out_user_r <= user_w;
      end else begin
        skid_data_r <= data_w;
        skid_user_r <= user_w;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* src/matrix3x3_inverse_unit.sv */
// Top level of the 3x3 matrix inverse unit.
//
// Usage: a matrix of nine signed fixed-point entries (WORD_BITS wide, FRACTION_BITS
// fraction bits) enters as one beat on the in_ stream, row by row in in_tdata.
// One beat leaves on the out_ stream with the inverse in the same layout, and
// out_tuser carries the singular flag (bit 0) and the saturated flag (bit 1).
// A determinant whose magnitude is below the threshold register gives the
// identity matrix with the singular flag set.
// Throughput: one matrix per cycle while the receiver does not stall. The path
// holds WORD_BITS + 8 register stages (five cofactor and determinant stages,
// an overflow check stage and one stage per quotient bit in each of the nine
// divider lanes, one clipping stage and the output register).
// The user writes the threshold through cfg_valid/cfg_data only while the unit
// is idle; the block does not enforce this. cfg_ready is always high.
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// threshold. When the receiver stalls, one more result is caught in a skid
// register and then in_tready falls and the whole pipeline holds.
module matrix3x3_inverse_unit #(
  parameter int WORD_BITS     = mi3x3_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = mi3x3_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((9*WORD_BITS+7)/8)*8-1:0]     in_tdata,
  // out_tdata: r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((9*WORD_BITS+7)/8)*8-1:0]     out_tdata,
  // out_tuser: singular (bit 0), saturated (bit 1)
  output logic [1:0]                           out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mi3x3_pkg::THR_W-1:0]          cfg_data
);

  localparam int W       = WORD_BITS;
  localparam int N       = mi3x3_pkg::NUM_ELEM;
  localparam int LANE_LAT = W + 2;

  logic                          en;
  logic [mi3x3_pkg::THR_W-1:0]   thr_r;
  logic signed [W-1:0]           elem   [N];
  logic [2*W:0]                  adj_mag [N];
  logic                          adj_neg [N];
  logic [3*W+2:0]                absdet;
  logic                          det_neg;
  logic signed [W-1:0]           lane_val [N];
  logic                          lane_sat [N];
  mi3x3_pkg::mi3x3_ctrl_t        front_ctrl;
  mi3x3_pkg::mi3x3_ctrl_t        ctrl_r [LANE_LAT];

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mi3x3_pkg::THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_tready = en;

  // Unpack the input beat.
  for (genvar k = 0; k < N; k++) begin : g_unpack
    assign elem[k] = $signed(in_tdata[k*W +: W]);
  end

  mi3x3_cofactor #(.W(W)) u_cofactor (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .elem_i    (elem),
    .thr_i     (thr_r),
    .adj_mag_o (adj_mag),
    .adj_neg_o (adj_neg),
    .absdet_o  (absdet),
    .det_neg_o (det_neg),
    .ctrl_o    (front_ctrl)
  );

  // Nine divider lanes, one per inverse entry.
  for (genvar k = 0; k < N; k++) begin : g_lane
    mi3x3_div_lane #(.W(W), .F(FRACTION_BITS)) u_lane (
      .clk       (clk),
      .en        (en),
      .adj_mag_i (adj_mag[k]),
      .neg_i     (adj_neg[k] ^ det_neg),
      .absdet_i  (absdet),
      .val_o     (lane_val[k]),
      .sat_o     (lane_sat[k])
    );
  end

  // Control rides beside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LANE_LAT; s++) begin
        ctrl_r[s] <= '0;
      end
    end else if (en) begin
      ctrl_r[0] <= front_ctrl;
      for (int s = 1; s < LANE_LAT; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
      end
    end
  end

  mi3x3_merge #(.W(W), .F(FRACTION_BITS)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (ctrl_r[LANE_LAT-1]),
    .val_i      (lane_val),
    .sat_i      (lane_sat),
    .en_o       (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* src/mi3x3_checker.sv */
// Port-level checks for the 3x3 matrix inverse unit, bound to its top level.
module mi3x3_checker #(
  parameter int W = mi3x3_pkg::WORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [((9*W+7)/8)*8-1:0]      out_tdata,
  input logic [1:0]                    out_tuser
);

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Input back-pressure only while a result waits at the output.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // A singular result is a diagonal matrix with equal diagonal entries.
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[W +: W] == '0 && out_tdata[2*W +: W] == '0 &&
      out_tdata[3*W +: W] == '0 && out_tdata[5*W +: W] == '0 &&
      out_tdata[6*W +: W] == '0 && out_tdata[7*W +: W] == '0 &&
      out_tdata[0 +: W] == out_tdata[4*W +: W] &&
      out_tdata[0 +: W] == out_tdata[8*W +: W])
    else $error("singular result is not the identity");

endmodule

bind matrix3x3_inverse_unit mi3x3_checker #(.W(WORD_BITS)) u_mi3x3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* verif/matrix3x3_inverse_unit_tb.sv */
// Self-checking testbench for the 3x3 matrix inverse unit: directed and random matrices.
module matrix3x3_inverse_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = mi3x3_pkg::WORD_BITS_DEF;
  localparam int F = mi3x3_pkg::FRACTION_BITS_DEF;
  localparam int DW = ((9 * W + 7) / 8) * 8;
  localparam int LATENCY = W + 7;
  localparam logic [W-1:0] Q_ONE = 32'h0001_0000;
  localparam logic [W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [W-1:0] Q_MIN = 32'h8000_0000;
  localparam int FLAG_SINGULAR = 0;
  localparam int FLAG_SATURATED = 1;

  typedef logic [DW-1:0] matrix_t;
  typedef struct packed {
    logic [1:0]  flags;
    logic [DW-1:0] ent;
  } inverse_t;
  typedef struct {
    matrix_t  m;
    logic     typed;
    inverse_t want;
  } vector_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [DW-1:0]  in_tdata = '0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [DW-1:0]  out_tdata;
  logic [1:0]     out_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [mi3x3_pkg::THR_W-1:0] cfg_data = '0;

  logic [mi3x3_pkg::THR_W-1:0] threshold = mi3x3_pkg::THR_RESET;
  inverse_t pending_inverses[$];
  int errors = 0;
  int beats_out = 0;
  int singular_seen = 0;
  int saturated_seen = 0;
  logic hold_rx = 1'b0;
  int rx_stall = 0;
  vector_t vectors[12];

  always #5 clk = ~clk;

  matrix3x3_inverse_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Exact adjugate inverse: wide integer products, truncating division, clipping.
  function automatic inverse_t predict_inverse(matrix_t m,
                                               logic [mi3x3_pkg::THR_W-1:0] thr);
    logic signed [191:0] e[9];
    logic signed [191:0] adj[9];
    logic signed [191:0] det;
    logic [191:0] absdet, mag, quo, quo_neg;
    logic neg;
    inverse_t r;
    r = '0;
    for (int k = 0; k < 9; k++) e[k] = $signed(m[k*W +: W]);
    for (int k = 0; k < mi3x3_pkg::NUM_ELEM; k++)
      adj[k] = e[mi3x3_pkg::ADJ_IDX[k][0]] * e[mi3x3_pkg::ADJ_IDX[k][1]]
             - e[mi3x3_pkg::ADJ_IDX[k][2]] * e[mi3x3_pkg::ADJ_IDX[k][3]];
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    absdet = (det < 0) ? -det : det;
    // Below threshold, or exactly zero: identity with the singular flag.
    if (det == 0 || absdet < {129'b0, thr}) begin
      r.flags[FLAG_SINGULAR] = 1'b1;
      for (int k = 0; k < 9; k += 4) r.ent[k*W +: W] = Q_ONE;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      mag = (adj[k] < 0) ? -adj[k] : adj[k];
      quo = (mag << (2 * F)) / absdet;
      neg = (adj[k] < 0) != (det < 0);
      quo_neg = -quo;
      if (neg && quo > {160'b0, Q_MIN}) begin
        r.ent[k*W +: W] = Q_MIN;
        r.flags[FLAG_SATURATED] = 1'b1;
      end else if (!neg && quo > {160'b0, Q_MAX}) begin
        r.ent[k*W +: W] = Q_MAX;
        r.flags[FLAG_SATURATED] = 1'b1;
      end else begin
        r.ent[k*W +: W] = neg ? quo_neg[W-1:0] : quo[W-1:0];
      end
    end
    return r;
  endfunction

  function automatic matrix_t diag_matrix(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    matrix_t m;
    m = '0;
    m[0 +: W] = a;
    m[4*W +: W] = b;
    m[8*W +: W] = c;
    return m;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random matrix: full range, moderate values, near-singular rows or tiny entries.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int lo, hi;
    kind = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (kind < 35) m[k*W +: W] = $urandom;
      else if (kind < 70) m[k*W +: W] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      else m[k*W +: W] = $urandom_range(0, 1024) - 512;
    end
    // Make the third row depend on the first two, exactly or almost.
    if (kind >= 85) begin
      for (int c = 0; c < 3; c++) begin
        lo = m[c*W +: W];
        hi = m[(3+c)*W +: W];
        m[(6+c)*W +: W] = lo + hi + $urandom_range(0, 2) - 1;
      end
    end
    return m;
  endfunction

  // Offer one matrix and hold it until the unit takes it.
  task automatic send_matrix(matrix_t m, logic typed, inverse_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= m;
    do @(posedge clk); while (!in_tready);
    pending_inverses.push_back(typed ? want : predict_inverse(m, threshold));
  endtask

  task automatic write_threshold(logic [mi3x3_pkg::THR_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  task automatic random_phase(int count);
    inverse_t none;
    none = '0;
    for (int n = 0; n < count; n++) send_matrix(random_matrix(), 1'b0, none);
  endtask

  // Result side: check each beat and pick the next ready level.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      beats_out <= beats_out + 1;
      if (out_tuser[FLAG_SINGULAR]) singular_seen <= singular_seen + 1;
      if (out_tuser[FLAG_SATURATED]) saturated_seen <= saturated_seen + 1;
      if (pending_inverses.size() == 0) begin
        $display("%0t: unexpected result beat data=%h flags=%b", $time, out_tdata, out_tuser);
        errors = errors + 1;
      end else begin
        inverse_t want;
        want = pending_inverses.pop_front();
        for (int k = 0; k < 9; k++)
          if (out_tdata[k*W +: W] !== want.ent[k*W +: W]) begin
            $display("%0t: entry %0d expected %h actual %h", $time, k,
                     want.ent[k*W +: W], out_tdata[k*W +: W]);
            errors = errors + 1;
          end
        if (out_tuser[FLAG_SINGULAR] !== want.flags[FLAG_SINGULAR]) begin
          $display("%0t: singular expected %b actual %b", $time,
                   want.flags[FLAG_SINGULAR], out_tuser[FLAG_SINGULAR]);
          errors = errors + 1;
        end
        if (out_tuser[FLAG_SATURATED] !== want.flags[FLAG_SATURATED]) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   want.flags[FLAG_SATURATED], out_tuser[FLAG_SATURATED]);
          errors = errors + 1;
        end
      end
    end
    if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_tready <= 1'b0;
    end else begin
      rx_stall <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  // Long receiver hold-off so the pipeline fills and the input stalls.
  initial begin
    repeat (600) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    inverse_t unit_inv, half_inv;
    // Directed vectors; the easy ones carry a typed-in answer.
    unit_inv = '0;
    for (int k = 0; k < 9; k += 4) unit_inv.ent[k*W +: W] = Q_ONE;
    half_inv = '0;
    for (int k = 0; k < 9; k += 4) half_inv.ent[k*W +: W] = 32'h0000_8000;
    vectors[0] = '{diag_matrix(Q_ONE, Q_ONE, Q_ONE), 1'b1, unit_inv};
    vectors[1] = '{'0, 1'b1, {2'b01, unit_inv.ent}};
    vectors[2] = '{{9{Q_MAX}}, 1'b1, {2'b01, unit_inv.ent}};
    vectors[3] = '{{9{Q_MIN}}, 1'b1, {2'b01, unit_inv.ent}};
    vectors[4] = '{diag_matrix(32'h2_0000, 32'h2_0000, 32'h2_0000), 1'b1, half_inv};
    vectors[5] = '{diag_matrix(32'h1, 32'h1, 32'h1), 1'b1, {2'b01, unit_inv.ent}};
    vectors[6] = '{diag_matrix(Q_MAX, Q_MAX, Q_MAX), 1'b0, '0};
    vectors[7] = '{diag_matrix(Q_MIN, Q_MIN, Q_MIN), 1'b0, '0};
    vectors[8] = '{diag_matrix(32'h1, Q_MAX, Q_MAX), 1'b0, '0};
    vectors[9] = '{diag_matrix(32'hFFFF_FFFF, Q_MAX, Q_MIN), 1'b0, '0};
    vectors[10] = '{{Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, Q_MIN, 32'h0, Q_MAX, 32'h0},
                    1'b0, '0};
    vectors[11] = '{diag_matrix(32'h1000, 32'hFFFF_F000, 32'h1000), 1'b0, '0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) send_matrix(vectors[i].m, vectors[i].typed, vectors[i].want);
    random_phase(250);
    write_threshold('0);
    foreach (vectors[i]) send_matrix(vectors[i].m, 1'b0, '0);
    random_phase(250);
    write_threshold({mi3x3_pkg::THR_W{1'b1}});
    random_phase(100);
    write_threshold(mi3x3_pkg::THR_W'({$urandom, $urandom} >> (1 + $urandom_range(0, 40))));
    random_phase(200);
    write_threshold(mi3x3_pkg::THR_RESET);
    random_phase(200);

    in_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d inverses over five threshold settings (zero and maximum included).",
             beats_out);
    $display("Singular results: %0d, saturated results: %0d.", singular_seen, saturated_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* matrix3x3_inverse_unit.f */
src/mi3x3_pkg.sv
src/mi3x3_cofactor.sv
src/mi3x3_div_lane.sv
src/mi3x3_merge.sv
src/matrix3x3_inverse_unit.sv
src/mi3x3_checker.sv
verif/matrix3x3_inverse_unit_tb.sv
